// ----- design/btac_pkg.sv -----
// Shared types, register map and reset values for the bump-and-turn controller.
package btac_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_REVERSE_TIME = 2'd0,
		REG_TURN_TIME    = 2'd1,
		REG_DRIVE_SPEED  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_FORWARD = 2'd0,
		MODE_LEFT    = 2'd1,
		MODE_RIGHT   = 2'd2,
		MODE_FRONT   = 2'd3
	} mode_t;

	localparam logic [15:0] REVERSE_TIME_RST = 16'd1000;
	localparam logic [15:0] TURN_TIME_RST    = 16'd1000;
	localparam logic [15:0] DRIVE_SPEED_RST  = 16'd12800;

	typedef struct packed {
		logic [15:0] reverse_time_ms;
		logic [15:0] turn_time_ms;
		logic [15:0] drive_speed;
	} cfg_t;

endpackage

// ----- design/btac_req_if.sv -----
// Request channel: one control tick with timestamp and bump flags.
interface btac_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        left_bumper;
	logic        right_bumper;

	modport source (output valid, output now_ms, output left_bumper, output right_bumper,
		input ready);
	modport sink (input valid, input now_ms, input left_bumper, input right_bumper,
		output ready);
endinterface

// ----- design/btac_res_if.sv -----
// Result channel: mode and motor settings after each tick.
interface btac_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        motors_running;
	logic        right_reverse;
	logic        left_reverse;
	logic [15:0] speed_out;

	modport source (output valid, output mode, output motors_running,
		output right_reverse, output left_reverse, output speed_out, input ready);
	modport sink (input valid, input mode, input motors_running,
		input right_reverse, input left_reverse, input speed_out, output ready);
endinterface

// ----- design/btac_core.sv -----
// Tick pipeline: input register, mode state update and result register.
module btac_core (
	input  logic           clk,
	input  logic           arst_n,
	input  btac_pkg::cfg_t cfg,
	btac_req_if.sink       req,
	btac_res_if.source     res
);

	logic        valid_s1;
	logic [31:0] now_s1;
	logic        left_bumper_s1;
	logic        right_bumper_s1;

	logic        res_valid_q;
	btac_pkg::mode_t mode_q;
	logic        pending_q;
	logic [31:0] entry_q;
	logic        run_q;
	logic        right_rev_q;
	logic        left_rev_q;
	logic [15:0] speed_q;

	btac_pkg::mode_t mode_d;
	logic        pending_d;
	logic [31:0] entry_d;
	logic        right_rev_d;
	logic        left_rev_d;
	logic        apply;
	logic [31:0] elapsed;
	logic [17:0] limit;
	logic        advance;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		mode_d      = mode_q;
		pending_d   = 1'b0;
		entry_d     = pending_q ? now_s1 : entry_q;
		right_rev_d = right_rev_q;
		left_rev_d  = left_rev_q;
		apply       = 1'b0;
		elapsed     = now_s1 - entry_d;
		limit       = {2'b00, cfg.reverse_time_ms} + {2'b00, cfg.turn_time_ms}
			+ ((mode_q == btac_pkg::MODE_FRONT) ? {2'b00, cfg.turn_time_ms} : 18'd0);
		if (mode_q == btac_pkg::MODE_FORWARD) begin
			if (pending_q) begin
				apply       = 1'b1;
				right_rev_d = 1'b0;
				left_rev_d  = 1'b0;
			end
			priority if (left_bumper_s1 && right_bumper_s1) begin
				mode_d = btac_pkg::MODE_FRONT;
			end else if (right_bumper_s1) begin
				mode_d = btac_pkg::MODE_RIGHT;
			end else if (left_bumper_s1) begin
				mode_d = btac_pkg::MODE_LEFT;
			end
		end else begin
			if (pending_q) begin
				apply       = 1'b1;
				right_rev_d = 1'b1;
				left_rev_d  = 1'b1;
			end
			if (elapsed > {16'd0, cfg.reverse_time_ms}) begin
				apply       = 1'b1;
				right_rev_d = (mode_q != btac_pkg::MODE_RIGHT);
				left_rev_d  = (mode_q == btac_pkg::MODE_RIGHT);
			end
			if (elapsed > {14'd0, limit}) begin
				mode_d = btac_pkg::MODE_FORWARD;
			end
		end
		pending_d = (mode_d != mode_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			mode_q      <= btac_pkg::MODE_FORWARD;
			pending_q   <= 1'b1;
			entry_q     <= '0;
			run_q       <= 1'b0;
			right_rev_q <= 1'b0;
			left_rev_q  <= 1'b0;
			speed_q     <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
				mode_q      <= mode_d;
				pending_q   <= pending_d;
				entry_q     <= entry_d;
				if (apply) begin
					run_q       <= 1'b1;
					right_rev_q <= right_rev_d;
					left_rev_q  <= left_rev_d;
					speed_q     <= cfg.drive_speed;
				end
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			now_s1          <= req.now_ms;
			left_bumper_s1  <= req.left_bumper;
			right_bumper_s1 <= req.right_bumper;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.mode           = mode_q;
	assign res.motors_running = run_q;
	assign res.right_reverse  = right_rev_q;
	assign res.left_reverse   = left_rev_q;
	assign res.speed_out      = speed_q;

endmodule

// ----- design/bump_turn_avoidance_controller.sv -----
// Top level of the bump-and-turn controller: register port and tick pipeline.
//
//   channel | dir | payload                                        | accepted when
//   req     | in  | now_ms, left_bumper, right_bumper              | valid && ready
//   res     | out | mode, motors_running, right/left_reverse, speed | valid && ready
//   apb     | in  | reverse_time_ms, turn_time_ms, drive_speed     | psel&penable&pwrite
//
// One request per cycle while the result is not stalled; a taken request passes the
// input register, then the result register, and updates the mode state once.
// Reset clears mode to forward with entry actions pending and motors stopped.
// A stalled result holds the input register; new requests wait only when both are full.
module bump_turn_avoidance_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	btac_req_if.sink                      req,
	btac_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [btac_pkg::ADDR_W-1:0]   paddr,
	input  logic [btac_pkg::DATA_W-1:0]   pwdata,
	output logic [btac_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	btac_pkg::cfg_t cfg_q;
	btac_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx    = btac_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_time_ms <= btac_pkg::REVERSE_TIME_RST;
			cfg_q.turn_time_ms    <= btac_pkg::TURN_TIME_RST;
			cfg_q.drive_speed     <= btac_pkg::DRIVE_SPEED_RST;
		end else if (wr_en) begin
			unique case (idx)
				btac_pkg::REG_REVERSE_TIME: cfg_q.reverse_time_ms <= pwdata[15:0];
				btac_pkg::REG_TURN_TIME:    cfg_q.turn_time_ms    <= pwdata[15:0];
				btac_pkg::REG_DRIVE_SPEED:  cfg_q.drive_speed     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			btac_pkg::REG_REVERSE_TIME: prdata = {16'd0, cfg_q.reverse_time_ms};
			btac_pkg::REG_TURN_TIME:    prdata = {16'd0, cfg_q.turn_time_ms};
			btac_pkg::REG_DRIVE_SPEED:  prdata = {16'd0, cfg_q.drive_speed};
			default:                    prdata = '0;
		endcase
	end

	btac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.res    (res)
	);

endmodule
